// ===== hdl/acl_pkg.sv =====
// shared constants, payload types and sequencer states for the autocorrelation block
package acl_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SMP_W       = 16;
  localparam int LAG_W       = 6;
  localparam int MEAN_W      = 32;
  localparam int MUL_W       = SMP_W;
  localparam int MUL_CNT_W   = $clog2(MUL_W);
  // product sum magnitude stays below 2^(2*SMP_W-2+ADDR_W), plus sign
  localparam int SUM_W       = 2 * SMP_W + ADDR_W;
  localparam int DIV_CNT_W   = $clog2(SUM_W);

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    last_sample;
  } acl_in_t;

  typedef struct packed {
    logic        [LAG_W-1:0]  lag;
    logic signed [MEAN_W-1:0] mean_product;
    logic                     last_result;
    logic                     truncated;
  } acl_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MUL,
    ST_DIVS,
    ST_DIV,
    ST_EMIT
  } acl_state_e;

endpackage

// ===== hdl/acl_div.sv =====
// bit-serial restoring divider: unsigned sum magnitude by lag pair count
module acl_div import acl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic [SUM_W-1:0] quot_o,
  output logic             done_o
);

  logic                 act_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0]     dq_q;
  logic [CNT_W-1:0]     rem_q;
  logic [CNT_W-1:0]     dvs_q;
  logic [CNT_W:0]       trial;
  logic                 fits;

  // one quotient bit per cycle, dividend shifts out as quotient shifts in
  assign trial = {rem_q, dq_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= act_q && !start_i && (cnt_q == DIV_CNT_W'(SUM_W - 1));
      if (start_i) begin
        act_q <= 1'b1;
        cnt_q <= '0;
      end else if (act_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(SUM_W - 1)) begin
          act_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (act_q) begin
      dq_q  <= {dq_q[SUM_W-2:0], fits};
      rem_q <= fits ? CNT_W'(trial - {1'b0, dvs_q}) : CNT_W'(trial);
    end
  end

  assign quot_o = dq_q;
  assign done_o = done_q;

endmodule

// ===== hdl/autocorrelation_all_lags.sv =====
// top level: sample store, bit-serial lag product sequencer and result strobe
//
// Input channel: an item (one Q8.8 sample plus last_sample) is taken at a
// rising edge with start_i high and busy_o low. Loading runs one sample per
// cycle; samples past MAX_SAMPLES are dropped and flagged as truncated.
// An item with last_sample set starts the run and raises busy_o.
// For each lag L of a series of N samples the block reads the N-L pairs from
// the store (two read ports, registered), forms each product with a shift-add
// multiplier one multiplier bit per cycle, then divides the sum by N-L in a
// restoring divider one quotient bit per cycle. The multiply loop and the
// serial divider set the time one lag takes (SUM_W = 38 at 64 samples).
// Results: res_valid_o is high for one cycle per lag, lag 1 first, with
// res_o valid in that cycle; the receiver cannot hold results off.
// busy_o drops the cycle after the largest lag is shown, with the store empty.
// A series of one sample gives no result and busy_o stays low.
// Reset empties the store and clears the truncation flag.
module autocorrelation_all_lags import acl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  acl_in_t  in_i,
  output logic     busy_o,
  output logic     res_valid_o,
  output acl_res_t res_o
);

  acl_state_e state_q, state_d;

  logic [CNT_W-1:0]     count_q;
  logic                 ovf_q;
  logic [ADDR_W-1:0]    lag_q;
  logic [ADDR_W-1:0]    i_q;
  logic [SMP_W-1:0]     mem [MAX_SAMPLES];
  logic [SMP_W-1:0]     rd_a_q;
  logic [SMP_W-1:0]     rd_b_q;
  logic [SUM_W-1:0]     sum_q;
  logic [SUM_W-1:0]     mcand_q;
  logic [MUL_W-1:0]     mult_q;
  logic                 psign_q;
  logic                 neg_q;
  logic [MUL_CNT_W-1:0] bit_q;

  logic                 accept;
  logic                 full;
  logic [CNT_W-1:0]     count_after;
  logic                 run_ok;
  logic [ADDR_W-1:0]    last_i;
  logic                 mul_end;
  logic                 div_start;
  logic                 div_done;
  logic [SUM_W-1:0]     sum_mag;
  logic [SUM_W-1:0]     quot;
  logic [MEAN_W-1:0]    quot_w;
  logic [CNT_W-1:0]     pairs;
  logic [SUM_W-1:0]     addend;

  function automatic logic [SMP_W-1:0] mag(input logic [SMP_W-1:0] v);
    return v[SMP_W-1] ? (~v + SMP_W'(1)) : v;
  endfunction

  assign accept      = start_i && (state_q == ST_IDLE);
  assign full        = count_q == CNT_W'(MAX_SAMPLES);
  assign count_after = full ? count_q : count_q + CNT_W'(1);
  assign run_ok      = count_after >= CNT_W'(2);
  assign last_i      = ADDR_W'(count_q - CNT_W'(1));
  assign mul_end     = bit_q == MUL_CNT_W'(MUL_W - 1);
  assign pairs       = count_q - CNT_W'(lag_q);
  assign sum_mag     = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
  assign addend      = psign_q ? (~mcand_q + SUM_W'(1)) : mcand_q;
  assign quot_w      = MEAN_W'(quot);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_i.last_sample && run_ok) state_d = ST_READ;
      end
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_MUL;
      ST_MUL: begin
        if (mul_end) state_d = (i_q == last_i) ? ST_DIVS : ST_READ;
      end
      ST_DIVS: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) state_d = ST_EMIT;
      end
      ST_EMIT: state_d = (lag_q == last_i) ? ST_IDLE : ST_READ;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy_o      = 1'b1;
    res_valid_o = 1'b0;
    div_start   = 1'b0;
    unique case (state_q)
      ST_IDLE: busy_o = 1'b0;
      ST_DIVS: div_start = 1'b1;
      ST_EMIT: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        // a lone sample ends its series with nothing to emit
        if (in_i.last_sample && !run_ok) begin
          count_q <= '0;
          ovf_q   <= 1'b0;
        end else if (!full) begin
          count_q <= count_q + CNT_W'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (state_q == ST_EMIT && lag_q == last_i) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end
    end
  end

  // sample store, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (accept && !full) mem[count_q[ADDR_W-1:0]] <= in_i.sample;
    if (state_q == ST_READ) begin
      rd_a_q <= mem[i_q];
      rd_b_q <= mem[i_q - lag_q];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_i.last_sample) begin
          lag_q <= ADDR_W'(1);
          i_q   <= ADDR_W'(1);
          sum_q <= '0;
        end
      end
      ST_LOAD: begin
        mcand_q <= SUM_W'(mag(rd_a_q));
        mult_q  <= mag(rd_b_q);
        psign_q <= rd_a_q[SMP_W-1] ^ rd_b_q[SMP_W-1];
        bit_q   <= '0;
      end
      ST_MUL: begin
        // shift-add, one multiplier bit per cycle straight into the sum
        if (mult_q[0]) sum_q <= sum_q + addend;
        mcand_q <= {mcand_q[SUM_W-2:0], 1'b0};
        mult_q  <= {1'b0, mult_q[MUL_W-1:1]};
        bit_q   <= bit_q + MUL_CNT_W'(1);
        if (mul_end) i_q <= i_q + ADDR_W'(1);
      end
      ST_DIVS: neg_q <= sum_q[SUM_W-1];
      ST_EMIT: begin
        if (lag_q != last_i) begin
          lag_q <= lag_q + ADDR_W'(1);
          i_q   <= lag_q + ADDR_W'(1);
          sum_q <= '0;
        end
      end
      default: ;
    endcase
  end

  acl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .divisor_i  (pairs),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  always_comb begin
    res_o.lag          = LAG_W'(lag_q);
    res_o.mean_product = neg_q ? (~quot_w + MEAN_W'(1)) : quot_w;
    res_o.last_result  = lag_q == last_i;
    res_o.truncated    = ovf_q;
  end

endmodule

// ===== hdl/acl_checker.sv =====
// port-level checks on the autocorrelation block, bound to the top level
module acl_checker import acl_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input acl_in_t  in_i,
  input logic     busy_o,
  input logic     res_valid_o,
  input acl_res_t res_o
);

  a_res_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy_o)
    else $error("result strobe outside a run");

  a_plain_sample_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !in_i.last_sample) |=> !busy_o)
    else $error("run started by an item not marked last");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_result) |=> !busy_o)
    else $error("block still busy after the largest lag");

  a_strobe_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("results on back-to-back cycles");

  a_lag_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.lag != '0))
    else $error("result with lag zero");

endmodule

bind autocorrelation_all_lags acl_checker u_acl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .in_i        (in_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the all-lags autocorrelation block
module tb;
  import acl_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int IDLE_PCT    = 31;
  localparam int TAIL_CYCLES = 100;

  typedef struct {
    acl_in_t item;
    bit      drain;  // hold this item back until all results are out
  } pending_t;

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     start_i = 1'b0;
  acl_in_t  in_i    = '0;
  logic     busy_o;
  logic     res_valid_o;
  acl_res_t res_o;

  pending_t                pending_q[$];
  acl_res_t                lag_means_q[$];
  logic signed [SMP_W-1:0] series_buf[MAX_SAMPLES];
  int                      series_len     = 0;
  bit                      series_dropped = 1'b0;
  int                      n_errors       = 0;
  int                      n_accepted     = 0;
  int                      n_cycles       = 0;

  autocorrelation_all_lags i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .in_i        (in_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always #2 clk_i = ~clk_i;

  // append one sample; a last one yields the mean for every lag
  task automatic load_sample(acl_in_t item);
    longint   sum;
    acl_res_t r;
    if (series_len < MAX_SAMPLES) begin
      series_buf[series_len] = item.sample;
      series_len++;
    end else begin
      series_dropped = 1'b1;
    end
    if (item.last_sample) begin
      for (int lag = 1; lag < series_len; lag++) begin
        sum = 0;
        for (int i = lag; i < series_len; i++) begin
          sum += longint'(series_buf[i]) * longint'(series_buf[i-lag]);
        end
        // signed division truncates toward zero
        sum = sum / longint'(series_len - lag);
        r.lag          = LAG_W'(lag);
        r.mean_product = sum[MEAN_W-1:0];
        r.last_result  = (lag == series_len - 1);
        r.truncated    = series_dropped;
        lag_means_q    = {lag_means_q, r};
      end
      series_len     = 0;
      series_dropped = 1'b0;
    end
  endtask

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return '0;
      3:       return '1;
      4, 5:    return SMP_W'(int'($urandom_range(0, 16)) - 8);
      default: return SMP_W'($urandom);
    endcase
  endfunction

  task automatic push_item(logic [SMP_W-1:0] s, bit last, bit drain);
    pending_t p;
    p.item.sample      = s;
    p.item.last_sample = last;
    p.drain            = drain;
    pending_q          = {pending_q, p};
  endtask

  task automatic push_series(int len, bit drain);
    for (int i = 0; i < len; i++) begin
      push_item(pick_sample(), i == len - 1, drain && i == 0);
    end
  endtask

  // sender
  always @(posedge clk_i) begin : drive_blk
    bit go;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        load_sample(pending_q[0].item);
        void'(pending_q.pop_front());
        n_accepted++;
      end
      go = pending_q.size() > 0;
      if (go && pending_q[0].drain && (lag_means_q.size() > 0 || busy_o)) go = 1'b0;
      // no idling while items 40 to 99 go in
      if (go && !(n_accepted >= 40 && n_accepted < 100) &&
          $urandom_range(0, 99) < IDLE_PCT) go = 1'b0;
      start_i <= go;
      if (go) in_i <= pending_q[0].item;
    end
  end

  // result checker
  always @(posedge clk_i) begin : check_blk
    acl_res_t want;
    if (rst_ni && res_valid_o) begin
      if (lag_means_q.size() == 0) begin
        report($sformatf("result with nothing expected, lag %0d", res_o.lag));
      end else begin
        want = lag_means_q.pop_front();
        if (res_o.lag !== want.lag)
          report($sformatf("lag got %0d want %0d", res_o.lag, want.lag));
        if (res_o.mean_product !== want.mean_product)
          report($sformatf("lag %0d mean got %0d want %0d", want.lag,
                           res_o.mean_product, want.mean_product));
        if (res_o.last_result !== want.last_result)
          report($sformatf("lag %0d last_result got %b want %b", want.lag,
                           res_o.last_result, want.last_result));
        if (res_o.truncated !== want.truncated)
          report($sformatf("lag %0d truncated got %b want %b", want.lag,
                           res_o.truncated, want.truncated));
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stim_blk
    int  len;
    bit  long_done;
    // extremes of the sample range
    push_item(16'h7fff, 1'b0, 1'b1);
    push_item(16'h7fff, 1'b1, 1'b0);
    push_item(16'h8000, 1'b0, 1'b0);
    push_item(16'h8000, 1'b1, 1'b0);
    push_item(16'h8000, 1'b0, 1'b0);
    push_item(16'h7fff, 1'b1, 1'b0);
    // single-sample series give nothing
    push_item(16'h0005, 1'b1, 1'b0);
    // negative means with a remainder
    push_item(16'h0001, 1'b0, 1'b1);
    push_item(16'hffff, 1'b0, 1'b0);
    push_item(16'h0000, 1'b0, 1'b0);
    push_item(16'h0001, 1'b1, 1'b0);
    push_item(16'hffff, 1'b0, 1'b0);
    push_item(16'h0002, 1'b0, 1'b0);
    push_item(16'hffff, 1'b1, 1'b0);
    push_item(16'h0000, 1'b0, 1'b0);
    push_item(16'h0000, 1'b1, 1'b0);
    push_item(16'h8000, 1'b1, 1'b0);
    push_item(16'h7fff, 1'b0, 1'b0);
    push_item(16'h8000, 1'b0, 1'b0);
    push_item(16'h7fff, 1'b0, 1'b0);
    push_item(16'h8000, 1'b0, 1'b0);
    push_item(16'h7fff, 1'b1, 1'b0);
    long_done = 1'b0;
    while (pending_q.size() < 150) begin
      if (!long_done && pending_q.size() >= 60) begin
        // store fills up, samples dropped up to and including the last one
        push_series(MAX_SAMPLES + 3, 1'b1);
        long_done = 1'b1;
      end
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 8);
      push_series(len, $urandom_range(0, 7) == 0);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() > 0 || start_i || lag_means_q.size() > 0 || busy_o)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && lag_means_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
